// ===== rtl/nhsp_pkg.sv =====
// Package for the HDM heading sentence parser: character codes, status codes,
// state encodings and small decode helpers. No dependencies.
package nhsp_pkg;

  // Default configuration
  localparam int MaxSentenceDef    = 82;
  localparam int FractionDigitsDef = 3;

  // Field widths fixed by the result format
  localparam int HeadingW = 19;
  localparam int StatusW  = 3;
  localparam int IntW     = 9;
  localparam int PosW     = 8;

  // Character codes
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_H      = 8'h48;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_D      = 8'h44;

  localparam logic [2:0] PrefixLen = 3'd6;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    STATUS_OK        = 3'd0,
    STATUS_BAD_HEX   = 3'd1,
    STATUS_CHECKSUM  = 3'd2,
    STATUS_PREFIX    = 3'd3,
    STATUS_NO_COMMA  = 3'd4,
    STATUS_SUFFIX    = 3'd5,
    STATUS_BAD_NUM   = 3'd6,
    STATUS_TOO_LONG  = 3'd7
  } status_e;

  // Sentence phase
  typedef enum logic [4:0] {
    PH_IDLE     = 5'b00001,
    PH_BODY     = 5'b00010,
    PH_HEX1     = 5'b00100,
    PH_HEX2     = 5'b01000,
    PH_HEX2_BAD = 5'b10000
  } phase_e;

  // Body field tracking
  typedef enum logic [4:0] {
    FS_PREFIX = 5'b00001,
    FS_NUMBER = 5'b00010,
    FS_SUFFIX = 5'b00100,
    FS_DONE   = 5'b01000,
    FS_DEAD   = 5'b10000
  } field_e;

  typedef struct packed {
    logic       bad;
    logic [3:0] nib;
  } hex_t;

  // Expected body prefix "HCHDM," by position
  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = CH_H;
      3'd1:    c = CH_C;
      3'd2:    c = CH_H;
      3'd3:    c = CH_D;
      3'd4:    c = CH_M;
      3'd5:    c = CH_COMMA;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Hex digit decode, either case
  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t h;
    h.bad = 1'b0;
    h.nib = 4'd0;
    if (b >= CH_0 && b <= CH_9) begin
      h.nib = 4'(b - CH_0);
    end else if (b >= CH_UA && b <= CH_UF) begin
      h.nib = 4'(b - CH_UA + 8'd10);
    end else if (b >= CH_LA && b <= CH_LF) begin
      h.nib = 4'(b - CH_LA + 8'd10);
    end else begin
      h.bad = 1'b1;
    end
    return h;
  endfunction

  // Powers of ten for fraction padding
  function automatic logic [19:0] pow10(input logic [2:0] n);
    logic [19:0] p;
    unique case (n)
      3'd0:    p = 20'd1;
      3'd1:    p = 20'd10;
      3'd2:    p = 20'd100;
      3'd3:    p = 20'd1000;
      3'd4:    p = 20'd10000;
      3'd5:    p = 20'd100000;
      3'd6:    p = 20'd1000000;
      default: p = 20'd0;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/nmea_heading_sentence_parser_core.sv =====
// HDM heading sentence parser, top level: byte-wise sentence checking and
// heading extraction with a two-deep result buffer. Depends on nhsp_pkg.
//
// Usage:
//   Input channel: one ASCII byte per request on data_byte_i, qualified by
//   in_valid_i and held off by in_stall_o. A '$' starts or restarts a
//   sentence; bytes outside a sentence are dropped.
//   Output channel: one result per sentence (accepted_o, heading_milli_o,
//   status_o) qualified by out_valid_o and held off by out_stall_i.
//   Throughput: one byte per cycle while in_stall_o is low. Each byte is
//   decoded against the parser state combinationally; the only loop is the
//   state register itself. A result is registered by the edge that accepts
//   the second checksum digit (or the body byte that overflows the length);
//   it is offered from that edge on unless the output register is held full.
//   Reset: the parser returns to idle, waiting for '$'; both result slots
//   are emptied.
//   Receiver stall: a result waiting in the output register does not hold
//   up input; a second result lands in a skid slot, and only while that
//   slot is occupied is in_stall_o raised.
module nmea_heading_sentence_parser_core #(
  parameter int MAX_SENTENCE    = nhsp_pkg::MaxSentenceDef,
  parameter int FRACTION_DIGITS = nhsp_pkg::FractionDigitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     data_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           accepted_o,
  output logic [nhsp_pkg::HeadingW-1:0]  heading_milli_o,
  output logic [nhsp_pkg::StatusW-1:0]   status_o
);
  import nhsp_pkg::*;

  localparam int FracW      = $clog2(10 ** FRACTION_DIGITS);
  localparam int CntW       = $clog2(FRACTION_DIGITS + 1);
  localparam int FullW      = $clog2(360 * (10 ** FRACTION_DIGITS));
  localparam int CalcW      = (FullW > HeadingW) ? FullW : HeadingW;
  localparam int IntScale   = 10 ** FRACTION_DIGITS;
  localparam logic [PosW-1:0] BodyLimit = PosW'(MAX_SENTENCE - 4);
  localparam logic [2:0]   FracDig    = 3'(FRACTION_DIGITS);

  typedef struct packed {
    logic                accepted;
    logic [HeadingW-1:0] heading;
    status_e             status;
  } result_t;

  // Parser state
  phase_e              phase_q, phase_d;
  logic [7:0]          xor_q, xor_d;
  logic [PosW-1:0]     pos_q, pos_d;
  field_e              stage_q, stage_d;
  logic [IntW-1:0]     int_q, int_d;
  logic [FracW-1:0]    frac_q, frac_d;
  logic [CntW-1:0]     fcnt_q, fcnt_d;
  logic                digit_q, digit_d;
  logic                point_q, point_d;
  logic                numbad_q, numbad_d;
  status_e             ferr_q, ferr_d;
  logic [3:0]          hnib_q, hnib_d;

  // Result buffer
  logic                out_valid_q, skid_valid_q;
  result_t             out_q, skid_q;

  logic                in_fire, out_fire;
  logic                res_valid;
  result_t             res;
  logic                fail_en;
  status_e             fail_code;
  hex_t                hx;
  logic [3:0]          digit_val;
  logic                is_digit;
  logic [12:0]         int_mac;
  logic [FracW+3:0]    frac_mac;
  logic [CalcW-1:0]    heading_full;
  logic [2:0]          pad_idx;
  status_e             chk_status;

  assign in_fire  = in_valid_i && !skid_valid_q;
  assign out_fire = out_valid_q && !out_stall_i;

  // Byte classification and arithmetic
  assign hx        = hex_decode(data_byte_i);
  assign is_digit  = (data_byte_i >= CH_0) && (data_byte_i <= CH_9);
  assign digit_val = 4'(data_byte_i - CH_0);
  assign int_mac   = 13'(int_q) * 13'd10 + 13'(digit_val);
  assign frac_mac  = (FracW+4)'(frac_q) * (FracW+4)'(10) + (FracW+4)'(digit_val);
  assign pad_idx   = FracDig - 3'(fcnt_q);
  assign heading_full = CalcW'(int_q) * CalcW'(IntScale)
                      + CalcW'(frac_q) * CalcW'(pow10(pad_idx));

  // Checksum-time status, in priority order
  always_comb begin
    if (phase_q == PH_HEX2_BAD || hx.bad) begin
      chk_status = STATUS_BAD_HEX;
    end else if ({hnib_q, hx.nib} != xor_q) begin
      chk_status = STATUS_CHECKSUM;
    end else if (ferr_q != STATUS_OK) begin
      chk_status = ferr_q;
    end else if (numbad_q || !digit_q) begin
      chk_status = STATUS_BAD_NUM;
    end else begin
      chk_status = STATUS_OK;
    end
  end

  // Next-state decode for one byte
  always_comb begin
    phase_d   = phase_q;
    xor_d     = xor_q;
    pos_d     = pos_q;
    stage_d   = stage_q;
    int_d     = int_q;
    frac_d    = frac_q;
    fcnt_d    = fcnt_q;
    digit_d   = digit_q;
    point_d   = point_q;
    numbad_d  = numbad_q;
    ferr_d    = ferr_q;
    hnib_d    = hnib_q;
    res_valid = 1'b0;
    res       = '{accepted: 1'b0, heading: '0, status: STATUS_OK};
    fail_en   = 1'b0;
    fail_code = STATUS_OK;

    if (data_byte_i == CH_DOLLAR) begin
      // Start or restart a sentence
      phase_d  = PH_BODY;
      xor_d    = '0;
      pos_d    = '0;
      stage_d  = FS_PREFIX;
      int_d    = '0;
      frac_d   = '0;
      fcnt_d   = '0;
      digit_d  = 1'b0;
      point_d  = 1'b0;
      numbad_d = 1'b0;
      ferr_d   = STATUS_OK;
      hnib_d   = '0;
    end else begin
      unique case (phase_q)
        PH_BODY: begin
          if (data_byte_i == CH_STAR) begin
            // End of body: anything not finished is a structural fault
            unique case (stage_q)
              FS_PREFIX: begin fail_en = 1'b1; fail_code = STATUS_PREFIX; end
              FS_NUMBER: begin fail_en = 1'b1; fail_code = STATUS_NO_COMMA; end
              FS_SUFFIX: begin fail_en = 1'b1; fail_code = STATUS_SUFFIX; end
              default: ;
            endcase
            phase_d = PH_HEX1;
          end else if (pos_q >= BodyLimit) begin
            res_valid = 1'b1;
            res.status = STATUS_TOO_LONG;
            phase_d   = PH_IDLE;
          end else begin
            unique case (stage_q)
              FS_PREFIX: begin
                if (pos_q >= PosW'(PrefixLen) ||
                    data_byte_i != prefix_char(pos_q[2:0])) begin
                  fail_en   = 1'b1;
                  fail_code = STATUS_PREFIX;
                end else if (pos_q[2:0] == PrefixLen - 3'd1) begin
                  stage_d = FS_NUMBER;
                end
              end
              FS_NUMBER: begin
                if (is_digit) begin
                  digit_d = 1'b1;
                  if (!point_q) begin
                    if (int_mac >= 13'd360) numbad_d = 1'b1;
                    else                   int_d = int_mac[IntW-1:0];
                  end else if (fcnt_q < CntW'(FRACTION_DIGITS)) begin
                    frac_d = frac_mac[FracW-1:0];
                    fcnt_d = fcnt_q + CntW'(1);
                  end
                end else if (data_byte_i == CH_POINT) begin
                  if (point_q) numbad_d = 1'b1;
                  point_d = 1'b1;
                end else if (data_byte_i == CH_COMMA) begin
                  stage_d = FS_SUFFIX;
                end else begin
                  numbad_d = 1'b1;
                end
              end
              FS_SUFFIX: begin
                if (data_byte_i == CH_M) begin
                  stage_d = FS_DONE;
                end else begin
                  fail_en   = 1'b1;
                  fail_code = STATUS_SUFFIX;
                end
              end
              FS_DONE: begin
                fail_en   = 1'b1;
                fail_code = STATUS_SUFFIX;
              end
              default: ;
            endcase
            pos_d = pos_q + PosW'(1);
            xor_d = xor_q ^ data_byte_i;
          end
        end
        PH_HEX1: begin
          hnib_d  = hx.nib;
          phase_d = hx.bad ? PH_HEX2_BAD : PH_HEX2;
        end
        PH_HEX2, PH_HEX2_BAD: begin
          res_valid    = 1'b1;
          res.status   = chk_status;
          res.accepted = (chk_status == STATUS_OK);
          res.heading  = (chk_status == STATUS_OK) ? heading_full[HeadingW-1:0] : '0;
          phase_d      = PH_IDLE;
        end
        default: phase_d = PH_IDLE;
      endcase
    end

    // First structural fault sticks; the body is dead from here on
    if (fail_en) begin
      if (ferr_q == STATUS_OK) ferr_d = fail_code;
      stage_d = FS_DEAD;
    end
  end

  // Parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      xor_q    <= '0;
      pos_q    <= '0;
      stage_q  <= FS_PREFIX;
      int_q    <= '0;
      frac_q   <= '0;
      fcnt_q   <= '0;
      digit_q  <= 1'b0;
      point_q  <= 1'b0;
      numbad_q <= 1'b0;
      ferr_q   <= STATUS_OK;
      hnib_q   <= '0;
    end else if (in_fire) begin
      phase_q  <= phase_d;
      xor_q    <= xor_d;
      pos_q    <= pos_d;
      stage_q  <= stage_d;
      int_q    <= int_d;
      frac_q   <= frac_d;
      fcnt_q   <= fcnt_d;
      digit_q  <= digit_d;
      point_q  <= point_d;
      numbad_q <= numbad_d;
      ferr_q   <= ferr_d;
      hnib_q   <= hnib_d;
    end
  end

  // Result buffer control: output register plus one skid slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_fire && res_valid;
      end
    end else if (in_fire && res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Result buffer payload
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_fire) begin
      if (skid_valid_q) out_q <= skid_q;
      else              out_q <= res;
    end else if (in_fire && res_valid) begin
      skid_q <= res;
    end
  end

  assign in_stall_o      = skid_valid_q;
  assign out_valid_o     = out_valid_q;
  assign accepted_o      = out_q.accepted;
  assign heading_milli_o = out_q.heading;
  assign status_o        = out_q.status;

endmodule

// ===== verif/nhsp_sentence_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the HDM heading sentence parser: watches both channels,
// tracks the sentence state byte by byte and compares each result.
// Depends on nhsp_pkg for character codes, status codes and state encodings.
module nhsp_sentence_checker #(
  parameter int MaxSentence = nhsp_pkg::MaxSentenceDef,
  parameter int FracDigits  = nhsp_pkg::FractionDigitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [7:0]                     data_byte_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic                           accepted_i,
  input  logic [nhsp_pkg::HeadingW-1:0]  heading_milli_i,
  input  logic [nhsp_pkg::StatusW-1:0]   status_i,
  output int                             error_count_o,
  output int                             pending_o,
  output int                             results_seen_o,
  output int                             headings_ok_o
);
  import nhsp_pkg::*;

  typedef struct packed {
    logic                accepted;
    logic [HeadingW-1:0] heading;
    status_e             status;
  } heading_result_t;

  localparam logic [47:0] HdmTag = "HCHDM,";

  // Results predicted but not yet seen on the output channel
  heading_result_t sentence_results[$];

  // Tracked sentence state
  phase_e      ph;
  field_e      fs;
  logic [7:0]  sum_x;
  logic [7:0]  body_len;
  int unsigned int_val;
  int unsigned frac_val;
  int unsigned frac_cnt;
  logic        has_digit;
  logic        has_point;
  logic        num_bad;
  status_e     first_fault;
  logic [3:0]  hi_nib;

  task automatic report_mismatch(input string msg);
    error_count_o++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic void clear_sentence();
    sum_x       = '0;
    body_len    = '0;
    fs          = FS_PREFIX;
    int_val     = 0;
    frac_val    = 0;
    frac_cnt    = 0;
    has_digit   = 1'b0;
    has_point   = 1'b0;
    num_bad     = 1'b0;
    first_fault = STATUS_OK;
    hi_nib      = '0;
  endfunction

  // Only the first structural fault is kept
  function automatic void set_fault(input status_e s);
    if (first_fault == STATUS_OK) first_fault = s;
    fs = FS_DEAD;
  endfunction

  // Hex value of a checksum digit, 16 when the byte is not hex
  function automatic int nibble_of(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b) - int'("0");
    if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
    if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
    return 16;
  endfunction

  function automatic logic [HeadingW-1:0] heading_of();
    longint v;
    longint f;
    int     k;
    v = longint'(int_val);
    f = longint'(frac_val);
    for (k = 0; k < FracDigits; k++) v = v * 10;
    for (k = frac_cnt; k < FracDigits; k++) f = f * 10;
    return HeadingW'(v + f);
  endfunction

  // Body byte against HCHDM,<number>,M
  function automatic void body_step(input logic [7:0] b);
    int unsigned d;
    int unsigned v;
    case (fs)
      FS_PREFIX: begin
        if (body_len >= 6 || b != HdmTag[8*(5-int'(body_len)) +: 8]) set_fault(STATUS_PREFIX);
        else if (body_len == 5) fs = FS_NUMBER;
      end
      FS_NUMBER: begin
        if (b >= CH_0 && b <= CH_9) begin
          d = 32'(b - CH_0);
          has_digit = 1'b1;
          if (!has_point) begin
            v = int_val * 10 + d;
            if (v >= 360) num_bad = 1'b1;
            else int_val = v;
          end else if (frac_cnt < FracDigits) begin
            // extra fraction digits are dropped, no rounding
            frac_val = frac_val * 10 + d;
            frac_cnt++;
          end
        end else if (b == CH_POINT) begin
          if (has_point) num_bad = 1'b1;
          has_point = 1'b1;
        end else if (b == CH_COMMA) begin
          fs = FS_SUFFIX;
        end else begin
          num_bad = 1'b1;
        end
      end
      FS_SUFFIX: begin
        if (b == CH_M) fs = FS_DONE;
        else set_fault(STATUS_SUFFIX);
      end
      FS_DONE: set_fault(STATUS_SUFFIX);
      default: ;
    endcase
  endfunction

  // One accepted byte; give is set when it completes a result
  function automatic void parse_byte(input logic [7:0] b, output logic give,
                                     output heading_result_t r);
    int      nib;
    status_e st;
    give       = 1'b0;
    r.accepted = 1'b0;
    r.heading  = '0;
    r.status   = STATUS_OK;
    if (b == CH_DOLLAR) begin
      clear_sentence();
      ph = PH_BODY;
    end else begin
      case (ph)
        PH_BODY: begin
          if (b == CH_STAR) begin
            case (fs)
              FS_PREFIX: set_fault(STATUS_PREFIX);
              FS_NUMBER: set_fault(STATUS_NO_COMMA);
              FS_SUFFIX: set_fault(STATUS_SUFFIX);
              default: ;
            endcase
            ph = PH_HEX1;
          end else if (int'(body_len) >= MaxSentence - 4) begin
            // '$' + body + "*hh" would not fit
            give     = 1'b1;
            r.status = STATUS_TOO_LONG;
            ph       = PH_IDLE;
          end else begin
            body_step(b);
            body_len = body_len + 8'd1;
            sum_x    = sum_x ^ b;
          end
        end
        PH_HEX1: begin
          nib    = nibble_of(b);
          hi_nib = nib[3:0];
          ph     = (nib < 16) ? PH_HEX2 : PH_HEX2_BAD;
        end
        PH_HEX2, PH_HEX2_BAD: begin
          nib = nibble_of(b);
          if (ph == PH_HEX2_BAD || nib >= 16) st = STATUS_BAD_HEX;
          else if ({hi_nib, nib[3:0]} != sum_x) st = STATUS_CHECKSUM;
          else if (first_fault != STATUS_OK) st = first_fault;
          else if (num_bad || !has_digit) st = STATUS_BAD_NUM;
          else st = STATUS_OK;
          give       = 1'b1;
          r.status   = st;
          r.accepted = (st == STATUS_OK);
          r.heading  = (st == STATUS_OK) ? heading_of() : '0;
          ph         = PH_IDLE;
        end
        default: ph = PH_IDLE;
      endcase
    end
  endfunction

  // Compare results first: a byte accepted on this edge cannot produce one yet
  always @(posedge clk_i or negedge rst_ni) begin : watch
    heading_result_t want;
    heading_result_t pred;
    logic            give;
    if (!rst_ni) begin
      ph = PH_IDLE;
      clear_sentence();
      sentence_results.delete();
      error_count_o  = 0;
      pending_o      = 0;
      results_seen_o = 0;
      headings_ok_o  = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        results_seen_o++;
        if (sentence_results.size() == 0) begin
          report_mismatch($sformatf("result with none expected (status %0d heading %0d)",
                                    status_i, heading_milli_i));
        end else begin
          want = sentence_results.pop_front();
          if (want.accepted) headings_ok_o++;
          if (accepted_i !== want.accepted)
            report_mismatch($sformatf("accepted %b, want %b", accepted_i, want.accepted));
          if (heading_milli_i !== want.heading)
            report_mismatch($sformatf("heading_milli %0d, want %0d",
                                      heading_milli_i, want.heading));
          if (status_i !== want.status)
            report_mismatch($sformatf("status %0d, want %0d (%s)",
                                      status_i, want.status, want.status.name()));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        parse_byte(data_byte_i, give, pred);
        if (give) sentence_results.push_back(pred);
      end
      pending_o = sentence_results.size();
    end
  end

endmodule

// ===== verif/tb_nmea_heading_sentence_parser_core.sv =====
`timescale 1ns / 1ps
// Testbench top for nmea_heading_sentence_parser_core: directed and random HDM
// sentences with idle and stall bursts. Depends on nhsp_pkg and nhsp_sentence_checker.
module tb_nmea_heading_sentence_parser_core;
  import nhsp_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int ByteTarget  = 1650;
  localparam int QuietAfter  = 1400;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_valid   = 1'b0;
  logic [7:0]          data_byte  = 8'h00;
  logic                out_stall  = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic                accepted;
  logic [HeadingW-1:0] heading_milli;
  logic [StatusW-1:0]  status;

  int error_count;
  int pending;
  int results_seen;
  int headings_ok;

  // Pacing knobs
  int gap_pct    = 0;
  int stall_pct  = 0;
  int stall_left = 0;
  logic quiet    = 1'b0;

  int cycles     = 0;
  int bytes_sent = 0;
  int sentences  = 0;

  logic [7:0] frame[$];

  always #5 clk = ~clk;

  nmea_heading_sentence_parser_core dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .data_byte_i     (data_byte),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .accepted_o      (accepted),
    .heading_milli_o (heading_milli),
    .status_o        (status)
  );

  nhsp_sentence_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .data_byte_i     (data_byte),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .accepted_i      (accepted),
    .heading_milli_i (heading_milli),
    .status_i        (status),
    .error_count_o   (error_count),
    .pending_o       (pending),
    .results_seen_o  (results_seen),
    .headings_ok_o   (headings_ok)
  );

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("tb_nmea_heading_sentence_parser_core: errors");
      $finish;
    end
  end

  // Receiver stall bursts, started at random by stall_pct
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 10);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // One byte request; returns at the edge that accepts it
  task automatic send_byte(input logic [7:0] b);
    int   gap;
    logic stalled;
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    bytes_sent++;
  endtask

  task automatic send_frame();
    int i;
    for (i = 0; i < frame.size(); i++) send_byte(frame[i]);
  endtask

  // Hold off the sender until every result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 10) return 8'(CH_0 + n);
    return 8'(($urandom_range(0, 1) ? CH_UA : CH_LA) + n - 10);
  endfunction

  function automatic logic [7:0] rand_text_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CH_DOLLAR || c == CH_STAR);
    return c;
  endfunction

  function automatic logic [7:0] bad_hex_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while ((c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UF) ||
           (c >= CH_LA && c <= CH_LF) || c == CH_DOLLAR);
    return c;
  endfunction

  // '$' + body + '*' + checksum; hex_fault 1/2 spoils the first/second digit
  function automatic void make_frame(input string body, input int hex_fault = 0,
                                     input logic [7:0] flip = 8'h00);
    logic [7:0] sum;
    int         i;
    sum = 8'h00;
    frame.delete();
    frame.push_back(CH_DOLLAR);
    for (i = 0; i < body.len(); i++) begin
      frame.push_back(8'(body[i]));
      sum = sum ^ 8'(body[i]);
    end
    frame.push_back(CH_STAR);
    sum = sum ^ flip;
    frame.push_back(hex_fault == 1 ? bad_hex_char() : hex_char(sum[7:4]));
    frame.push_back(hex_fault == 2 ? bad_hex_char() : hex_char(sum[3:0]));
  endfunction

  task automatic send_body(input string body, input int hex_fault = 0,
                           input logic [7:0] flip = 8'h00);
    make_frame(body, hex_fault, flip);
    send_frame();
    sentences++;
  endtask

  function automatic string digit_run(input int n, input logic rnd);
    string s;
    int    k;
    s = "";
    for (k = 0; k < n; k++) s = $sformatf("%s%0d", s, rnd ? $urandom_range(0, 9) : 0);
    return s;
  endfunction

  // Well-formed number below 360, in the forms the parser accepts
  function automatic string rand_heading();
    int    whole;
    int    nfrac;
    logic  with_point;
    string s;
    whole = ($urandom_range(0, 7) == 0) ? 359 : $urandom_range(0, 359);
    case ($urandom_range(0, 4))
      0:       s = "";
      1:       s = $sformatf("%03d", whole);
      default: s = $sformatf("%0d", whole);
    endcase
    nfrac = $urandom_range(0, 6);
    with_point = (s.len() == 0) || ($urandom_range(0, 2) != 0);
    if (s.len() == 0 && nfrac == 0) nfrac = 1;
    if (with_point) s = {s, ".", digit_run(nfrac, 1'b1)};
    return s;
  endfunction

  function automatic string bad_number();
    case ($urandom_range(0, 7))
      0: return "";
      1: return ".";
      2: return $sformatf("%0d.%0d.%0d", $urandom_range(0, 99), $urandom_range(0, 9),
                          $urandom_range(0, 9));
      3: return $sformatf("%0d", $urandom_range(360, 9999));
      4: return $sformatf("%0d%c%0d", $urandom_range(0, 35), rand_text_char(),
                          $urandom_range(0, 9));
      5: return $sformatf("%c%0d", $urandom_range(0, 1) ? "-" : "+", $urandom_range(0, 359));
      6: return $sformatf("%0de%0d", $urandom_range(1, 9), $urandom_range(0, 2));
      default: return $sformatf(" %0d", $urandom_range(0, 359));
    endcase
  endfunction

  function automatic string bad_suffix();
    case ($urandom_range(0, 4))
      0: return ",";
      1: return ",T";
      2: return ",MM";
      3: return ",M,";
      default: return $sformatf(",%c", rand_text_char());
    endcase
  endfunction

  // Pacing for the next sentence, including stretches with none
  task automatic set_pace();
    case ($urandom_range(0, 3))
      0:       begin gap_pct <= 0;  stall_pct <= 0;  end
      1:       begin gap_pct <= 25; stall_pct <= 30; end
      default: begin gap_pct <= 6;  stall_pct <= 8;  end
    endcase
  endtask

  task automatic directed_cases();
    logic [7:0] idle_noise[5];
    int         i;
    idle_noise = '{8'h00, 8'hFF, CH_H, CH_STAR, 8'h35};
    // bytes outside a sentence are dropped
    foreach (idle_noise[i]) send_byte(idle_noise[i]);
    send_body("HCHDM,0,M");
    send_body("HCHDM,359.999,M");
    send_body("HCHDM,359.99999,M");
    send_body("HCHDM,.5,M");
    send_body("HCHDM,7.,M");
    send_body("HCHDM,007.25,M");
    send_body("HCHDM,360,M");
    send_body("HCHDM,.,M");
    send_body("HCHDM,,M");
    send_body("HCHDM,1.2.3,M");
    send_body("HCHDM,-5,M");
    send_body("HCH");
    send_body("");
    send_body("GPHDT,5,T");
    send_body("HCHDM,12");
    send_body("HCHDM,12,");
    send_body("HCHDM,12,MX");
    send_body("HCHDM,90,M", 0, 8'h5A);
    send_body("HCHDM,90,M", 1);
    send_body("HCHDM,90,M", 2);
    send_body("HCXDM,90,M", 1);
    send_body("HCHDM,90,T", 0, 8'h01);
    // restart in the middle of a sentence
    make_frame("HCHDM,12,M");
    for (i = 0; i < 6; i++) send_byte(frame[i]);
    send_body("HCHDM,271.5,M");
    // longest body that fits, then one byte more
    send_body({"HCHDM,1.", digit_run(68, 1'b0), ",M"});
    send_body({"HCHDM,1.", digit_run(69, 1'b0), ",M"});
  endtask

  task automatic random_sentence();
    int    kind;
    int    k;
    int    i;
    string body;
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 12) begin
      k = $urandom_range(1, 4);
      for (i = 0; i < k; i++) send_byte(8'($urandom_range(0, 255)));
    end
    if (kind < 50) begin
      send_body({"HCHDM,", rand_heading(), ",M"});
    end else if (kind < 58) begin
      send_body({"HCHDM,", rand_heading(), ",M"}, 0, 8'($urandom_range(1, 255)));
    end else if (kind < 64) begin
      send_body({"HCHDM,", rand_heading(), ",M"}, $urandom_range(1, 2));
    end else if (kind < 71) begin
      if ($urandom_range(0, 2) == 0) begin
        body = "HCHDM,";
        k = $urandom_range(0, 5);
        body = (k == 0) ? "" : body.substr(0, k - 1);
      end else begin
        body = {"HCHDM,", rand_heading(), ",M"};
        body.putc($urandom_range(0, 5), rand_text_char());
      end
      send_body(body);
    end else if (kind < 76) begin
      send_body({"HCHDM,", rand_heading()});
    end else if (kind < 82) begin
      send_body({"HCHDM,", rand_heading(), bad_suffix()});
    end else if (kind < 91) begin
      send_body({"HCHDM,", bad_number(), ",M"});
    end else if (kind < 95) begin
      make_frame({"HCHDM,", rand_heading(), ",M"});
      k = $urandom_range(1, frame.size() - 1);
      for (i = 0; i < k; i++) send_byte(frame[i]);
      send_body({"HCHDM,", rand_heading(), ",M"});
    end else if (kind < 97) begin
      send_body({"HCHDM,1.", digit_run($urandom_range(69, 85), 1'b1), ",M"});
    end else begin
      k = $urandom_range(1, 8);
      for (i = 0; i < k; i++) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_pace();
    directed_cases();
    drain_results();

    while (bytes_sent < ByteTarget) begin
      if (bytes_sent >= QuietAfter) quiet <= 1'b1;
      set_pace();
      random_sentence();
      if (sentences % 25 == 0) drain_results();
    end

    drain_results();
    repeat (20) @(posedge clk);
    @(negedge clk);
    $display("Sent %0d bytes in %0d sentences plus noise; checked %0d results, %0d headings ok.",
             bytes_sent, sentences, results_seen, headings_ok);
    $display("Covered bad hex, checksum, prefix, comma, suffix, number and length faults.");
    if (error_count == 0) begin
      $display("tb_nmea_heading_sentence_parser_core: clean");
    end else begin
      $display("%0d mismatches", error_count);
      $display("tb_nmea_heading_sentence_parser_core: errors");
    end
    $finish;
  end

endmodule
